// ----- sv/skit_pkg.sv -----
// ----------------------------------------------------------------------------
// skit_pkg: shared types and constants of the sorted key index table
// Field widths, status and operation codes, the cell control word and the
// depth of the registered match-reduction tree.
// ----------------------------------------------------------------------------
`default_nettype none

package skit_pkg;

	// default sizes of the table
	localparam int DEPTH_DEF    = 128;
	localparam int KEY_BITS_DEF = 16;

	// fixed field widths on the ports
	localparam int IN_KEY_W  = 16;
	localparam int POS_W     = 7;
	localparam int HELD_W    = 8;
	localparam int STATUS_W  = 2;

	// match tree: one hit flag plus the masked position per leaf
	localparam int FANIN  = 8;
	localparam int LEAF_W = POS_W + 1;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic load_en;
	} cell_ctl_t;

	// number of registered levels needed to fold depth leaves to one root
	function automatic int tree_levels(input int depth);
		int n;
		int lv;
		n = depth;
		lv = 0;
		while (n > 1) begin
			n = (n + FANIN - 1) / FANIN;
			lv = lv + 1;
		end
		return lv;
	endfunction

endpackage

`default_nettype wire

// ----- sv/skit_cell.sv -----
// ----------------------------------------------------------------------------
// skit_cell: one slot of the sorted key chain
// Holds one key and position, compares the key against the broadcast key and,
// on an insert, takes the entry of its lower neighbor or the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_cell #(
	parameter int KEY_BITS = skit_pkg::KEY_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire skit_pkg::cell_ctl_t           ctl,
	input  wire logic [KEY_BITS-1:0]           key_in,
	input  wire logic [skit_pkg::POS_W-1:0]    pos_in,
	input  wire logic                          occupied,
	input  wire logic                          at_end,
	input  wire logic                          prev_shift,
	input  wire logic [KEY_BITS-1:0]           prev_key,
	input  wire logic [skit_pkg::POS_W-1:0]    prev_pos,
	output logic [KEY_BITS-1:0]                key_out,
	output logic [skit_pkg::POS_W-1:0]         pos_out,
	output logic                               shift_out,
	output logic [skit_pkg::LEAF_W-1:0]        leaf
);

	logic [KEY_BITS-1:0]        key_q;
	logic [skit_pkg::POS_W-1:0] pos_q;
	logic                       shift_q;
	logic                       eq_q;

	// compare flags: this slot moves up on insert, or holds the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			eq_q    <= 1'b0;
		end else if (ctl.cmp_en) begin
			shift_q <= occupied ? (key_q > key_in) : at_end;
			eq_q    <= occupied && (key_q == key_in);
		end
	end

	// entry storage: neighbor data when it shifts too, else the new entry
	always_ff @(posedge clk) begin
		if (ctl.load_en && shift_q) begin
			if (prev_shift) begin
				key_q <= prev_key;
				pos_q <= prev_pos;
			end else begin
				key_q <= key_in;
				pos_q <= pos_in;
			end
		end
	end

	assign key_out   = key_q;
	assign pos_out   = pos_q;
	assign shift_out = shift_q;
	assign leaf      = {eq_q, pos_q & {skit_pkg::POS_W{eq_q}}};

endmodule

`default_nettype wire

// ----- sv/skit_tree.sv -----
// ----------------------------------------------------------------------------
// skit_tree: registered OR tree over the cell match leaves
// Folds eight leaves per node per level; the root carries the hit flag and
// the position of the single matching cell.
// ----------------------------------------------------------------------------
`default_nettype none

module skit_tree #(
	parameter int DEPTH = skit_pkg::DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic [skit_pkg::LEAF_W-1:0]  leaf [DEPTH],
	output logic [skit_pkg::LEAF_W-1:0]       root
);

	localparam int LEVELS = skit_pkg::tree_levels(DEPTH);

	logic [skit_pkg::LEAF_W-1:0] node_q [LEVELS][DEPTH];

	// one register level per fold; nodes past the used range stay zero
	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		for (genvar j = 0; j < DEPTH; j++) begin : g_node
			if (l == 0) begin : g_first
				always_ff @(posedge clk) begin
					logic [skit_pkg::LEAF_W-1:0] acc;
					acc = '0;
					for (int k = 0; k < skit_pkg::FANIN; k++) begin
						if (j * skit_pkg::FANIN + k < DEPTH) begin
							acc = acc | leaf[j * skit_pkg::FANIN + k];
						end
					end
					node_q[l][j] <= acc;
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					logic [skit_pkg::LEAF_W-1:0] acc;
					acc = '0;
					for (int k = 0; k < skit_pkg::FANIN; k++) begin
						if (j * skit_pkg::FANIN + k < DEPTH) begin
							acc = acc | node_q[l-1][j * skit_pkg::FANIN + k];
						end
					end
					node_q[l][j] <= acc;
				end
			end
		end
	end

	assign root = node_q[LEVELS-1][0];

endmodule

`default_nettype wire

// ----- sv/sorted_key_index_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_index_table: sorted key to record position table
// Holds up to DEPTH key and position pairs in ascending key order in a chain
// of cells; serves insert and lookup words with one result word each.
// ----------------------------------------------------------------------------
// Usage
//   s_* stream: command words. s_tuser selects insert or lookup; s_tdata
//   carries key and record position. A word is taken when s_tvalid and
//   s_tready are high at a clock edge.
//   m_* stream: one result word per command: status in m_tuser, found
//   position and entry count in m_tdata.
//   Each command passes a broadcast compare in every cell, then a registered
//   OR tree of L = ceil(log8(DEPTH)) levels (3 at DEPTH 128), then a commit
//   step that shifts the cells on an insert. The result word is registered
//   at the commit, and a new command is taken only once the previous one has
//   been committed.
//   While a result waits in the output register the next command is taken;
//   its commit waits until that result is taken by the receiver.
//   Reset empties the table at once (count cleared); stored keys are not
//   cleared, only slots below the count are ever compared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_index_table #(
	parameter int DEPTH    = skit_pkg::DEPTH_DEF,
	parameter int KEY_BITS = skit_pkg::KEY_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // key[15:0], record_position[22:16], zero pad
	input  wire logic [0:0]  s_tuser,   // opcode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // found_position[6:0], entries_held[14:7], zero pad
	output logic [1:0]       m_tuser    // status[1:0]
);

	localparam int CW     = $clog2(DEPTH + 1);
	localparam int LEVELS = skit_pkg::tree_levels(DEPTH);
	localparam int LCW    = $clog2(LEVELS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_TREE = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [LCW-1:0]                lvl_cnt_q;
	logic [CW-1:0]                 count_q;
	skit_pkg::op_t                 op_q;
	logic [KEY_BITS-1:0]           key_q;
	logic [skit_pkg::POS_W-1:0]    pos_q;

	logic                          m_tvalid_q;
	skit_pkg::status_t             status_q;
	logic [skit_pkg::POS_W-1:0]    found_q;
	logic [skit_pkg::HELD_W-1:0]   held_q;

	logic [31:0]                   key_wide;
	logic [KEY_BITS-1:0]           key_in;
	logic                          out_free;
	logic                          commit;
	logic                          full;
	logic                          hit;
	logic                          ins_ok;
	logic [CW-1:0]                 count_next;
	logic [31:0]                   held_wide;
	skit_pkg::status_t             status_d;
	logic [skit_pkg::POS_W-1:0]    found_d;
	skit_pkg::cell_ctl_t           ctl;
	logic [skit_pkg::LEAF_W-1:0]   root;

	logic [KEY_BITS-1:0]           cell_key   [DEPTH];
	logic [skit_pkg::POS_W-1:0]    cell_pos   [DEPTH];
	logic                          cell_shift [DEPTH];
	logic [skit_pkg::LEAF_W-1:0]   cell_leaf  [DEPTH];

	// key taken from the low KEY_BITS of the input key field
	assign key_wide = {16'd0, s_tdata[skit_pkg::IN_KEY_W-1:0]};
	assign key_in   = key_wide[KEY_BITS-1:0];

	// decision at commit
	assign out_free   = !m_tvalid_q || m_tready;
	assign commit     = (state_q == S_DONE) && out_free;
	assign full       = (count_q == CW'(DEPTH));
	assign hit        = root[skit_pkg::LEAF_W-1];
	assign ins_ok     = (op_q == skit_pkg::OP_INSERT) && !full && !hit;
	assign count_next = ins_ok ? count_q + CW'(1) : count_q;
	assign held_wide  = 32'(count_next);

	always_comb begin
		found_d = '0;
		if (op_q == skit_pkg::OP_INSERT) begin
			if (full) begin
				status_d = skit_pkg::ST_FULL;
			end else if (hit) begin
				status_d = skit_pkg::ST_DUPLICATE;
			end else begin
				status_d = skit_pkg::ST_OK;
			end
		end else if (hit) begin
			status_d = skit_pkg::ST_OK;
			found_d  = root[skit_pkg::POS_W-1:0];
		end else begin
			status_d = skit_pkg::ST_NOT_FOUND;
		end
	end

	assign ctl.cmp_en  = (state_q == S_CMP);
	assign ctl.load_en = commit && ins_ok;

	// sequencer: accept, compare, fold the tree, commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lvl_cnt_q <= '0;
			count_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					lvl_cnt_q <= LCW'(LEVELS);
					state_q   <= S_TREE;
				end
				S_TREE: begin
					lvl_cnt_q <= lvl_cnt_q - LCW'(1);
					if (lvl_cnt_q == LCW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						count_q <= count_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command word capture
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= skit_pkg::op_t'(s_tuser[0]);
			key_q <= key_in;
			pos_q <= s_tdata[22:16];
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			found_q  <= found_d;
			held_q   <= held_wide[skit_pkg::HELD_W-1:0];
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, held_q, found_q};
	assign m_tuser  = status_q;

	// chain of cells, slot 0 holds the smallest key
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                       prev_shift;
		logic [KEY_BITS-1:0]        prev_key;
		logic [skit_pkg::POS_W-1:0] prev_pos;

		if (i == 0) begin : g_head
			assign prev_shift = 1'b0;
			assign prev_key   = '0;
			assign prev_pos   = '0;
		end else begin : g_link
			assign prev_shift = cell_shift[i-1];
			assign prev_key   = cell_key[i-1];
			assign prev_pos   = cell_pos[i-1];
		end

		skit_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_in    (key_q),
			.pos_in    (pos_q),
			.occupied  (count_q > CW'(i)),
			.at_end    (count_q == CW'(i)),
			.prev_shift(prev_shift),
			.prev_key  (prev_key),
			.prev_pos  (prev_pos),
			.key_out   (cell_key[i]),
			.pos_out   (cell_pos[i]),
			.shift_out (cell_shift[i]),
			.leaf      (cell_leaf[i])
		);
	end

	// match reduction over all cells
	skit_tree #(
		.DEPTH(DEPTH)
	) u_tree (
		.clk (clk),
		.leaf(cell_leaf),
		.root(root)
	);

	// count never runs past the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table size");

	// count grows by one and only at a commit
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && (count_q != $past(count_q)) |->
			(count_q == $past(count_q) + CW'(1)) && ($past(state_q) == S_DONE))
		else $error("entry count changed outside an insert commit");

	// a lookup leaves the count alone
	a_lookup_count: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (op_q == skit_pkg::OP_LOOKUP) |=> $stable(count_q))
		else $error("lookup changed the entry count");

	// a new result word only follows a commit
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $rose(m_tvalid_q) |-> $past(state_q) == S_DONE)
		else $error("result word without commit");

	// tree wait counter is live while folding
	a_tree_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TREE) |-> (lvl_cnt_q != '0))
		else $error("tree wait counter empty while folding");

endmodule

`default_nettype wire

// ----- tb/sv/sorted_key_index_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_index_table_tb: self-checking bench for the sorted key table
// Drives insert and lookup words through the command stream, keeps a
// behavioral copy of the sorted table to work out each result word, and
// compares every result word field by field in order. A short directed
// table comes first, then random traffic that fills the table to capacity,
// under several sender and receiver idling mixes and one long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------

module sorted_key_index_table_tb;

	localparam int TABLE_DEPTH    = skit_pkg::DEPTH_DEF;
	localparam int RANDOM_WORDS   = 107;   // per idling phase, four phases
	localparam int LONG_HOLD      = 240;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int REPORT_LIMIT   = 10;

	// one result word: status, found position, entry count
	typedef struct packed {
		logic [skit_pkg::STATUS_W-1:0] status;
		logic [skit_pkg::POS_W-1:0]    found;
		logic [skit_pkg::HELD_W-1:0]   held;
	} table_result_t;

	// one directed command, with a typed-in result where it is obvious
	typedef struct packed {
		logic [0:0]                    op;
		logic [skit_pkg::IN_KEY_W-1:0] key;
		logic [skit_pkg::POS_W-1:0]    pos;
		logic                          typed;
		table_result_t                 result;
	} directed_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	// behavioral copy of the table
	logic [skit_pkg::IN_KEY_W-1:0] table_keys [0:TABLE_DEPTH-1];
	logic [skit_pkg::POS_W-1:0]    table_positions [0:TABLE_DEPTH-1];
	int                            table_count;

	table_result_t expected_results [$];
	directed_cmd_t directed_cmds [$];

	int failures;
	int src_idle_pct;
	int sink_stall_pct;
	int holds_requested;
	int holds_served;
	int quiet_cycles;

	sorted_key_index_table DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// binary search, then insert with shift or lookup
	function automatic table_result_t apply_table_op(input logic [0:0] op,
			input logic [skit_pkg::IN_KEY_W-1:0] key,
			input logic [skit_pkg::POS_W-1:0] pos);
		table_result_t r;
		int lo;
		int hi;
		int mid;
		int slot;
		int i;
		bit hit;
		r.status = skit_pkg::ST_OK;
		r.found  = '0;
		lo = 0;
		hi = table_count;
		hit = 1'b0;
		slot = 0;
		while (lo < hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (table_keys[mid] == key) begin
				hit = 1'b1;
				slot = mid;
			end else if (key < table_keys[mid]) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		if (!hit)
			slot = lo;
		if (op == skit_pkg::OP_INSERT) begin
			if (table_count >= TABLE_DEPTH) begin
				r.status = skit_pkg::ST_FULL;
			end else if (hit) begin
				r.status = skit_pkg::ST_DUPLICATE;
			end else begin
				for (i = table_count; i > slot; i--) begin
					table_keys[i]      = table_keys[i-1];
					table_positions[i] = table_positions[i-1];
				end
				table_keys[slot]      = key;
				table_positions[slot] = pos;
				table_count++;
			end
		end else if (hit) begin
			r.found = table_positions[slot];
		end else begin
			r.status = skit_pkg::ST_NOT_FOUND;
		end
		r.held = table_count[skit_pkg::HELD_W-1:0];
		return r;
	endfunction

	// offer one command word, record its expected result on acceptance
	task automatic send_word(input logic [0:0] op,
			input logic [skit_pkg::IN_KEY_W-1:0] key,
			input logic [skit_pkg::POS_W-1:0] pos, input logic typed,
			input table_result_t typed_result);
		table_result_t r;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, pos, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = apply_table_op(op, key, pos);
		expected_results.push_back(typed ? typed_result : r);
		@(negedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off when one is requested
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_requested) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				holds_served++;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		table_result_t got;
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.found  = m_tdata[6:0];
			got.held   = m_tdata[14:7];
			if (expected_results.size() == 0) begin
				if (failures < REPORT_LIMIT)
					$display("unexpected result word: status %0d pos %0d held %0d",
						got.status, got.found, got.held);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					if (failures < REPORT_LIMIT) begin
						$write("mismatch: expected status %0d pos %0d held %0d, ",
							want.status, want.found, want.held);
						$display("got status %0d pos %0d held %0d",
							got.status, got.found, got.held);
					end
					failures++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("sorted_key_index_table_tb NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		directed_cmd_t c;
		table_result_t none;
		logic [0:0] op;
		logic [skit_pkg::IN_KEY_W-1:0] key;
		logic [skit_pkg::POS_W-1:0] pos;
		int ph;
		int n;
		int pick;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;
		failures = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		holds_requested = 0;
		holds_served = 0;
		quiet_cycles = 0;
		table_count = 0;
		none = '0;

		// directed: empty table, key extremes, slot-zero and middle inserts,
		// duplicates, hits and misses
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h1234, 7'h00, 1'b1,
			skit_pkg::ST_NOT_FOUND, 7'd0, 8'd0});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'hFFFF, 7'h7F, 1'b1,
			skit_pkg::ST_NOT_FOUND, 7'd0, 8'd0});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h8000, 7'h55, 1'b1,
			skit_pkg::ST_OK, 7'd0, 8'd1});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h0000, 7'h7F, 1'b1,
			skit_pkg::ST_OK, 7'd0, 8'd2});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'hFFFF, 7'h00, 1'b1,
			skit_pkg::ST_OK, 7'd0, 8'd3});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h8000, 7'h01, 1'b1,
			skit_pkg::ST_DUPLICATE, 7'd0, 8'd3});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h0000, 7'h00, 1'b1,
			skit_pkg::ST_OK, 7'h7F, 8'd3});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'hFFFF, 7'h00, 1'b1,
			skit_pkg::ST_OK, 7'h00, 8'd3});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h8000, 7'h00, 1'b1,
			skit_pkg::ST_OK, 7'h55, 8'd3});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h7FFF, 7'h00, 1'b1,
			skit_pkg::ST_NOT_FOUND, 7'd0, 8'd3});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h7FFF, 7'h2A, 1'b1,
			skit_pkg::ST_OK, 7'd0, 8'd4});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h0001, 7'h01, 1'b1,
			skit_pkg::ST_OK, 7'd0, 8'd5});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h7FFF, 7'h7F, 1'b1,
			skit_pkg::ST_OK, 7'h2A, 8'd5});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h0001, 7'h00, 1'b1,
			skit_pkg::ST_OK, 7'h01, 8'd5});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h0000, 7'h33, 1'b1,
			skit_pkg::ST_DUPLICATE, 7'd0, 8'd5});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'hFFFE, 7'h40, 1'b0, none});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'hFFFE, 7'h00, 1'b0, none});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h8001, 7'h00, 1'b0, none});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'h5555, 7'h2A, 1'b0, none});
		directed_cmds.push_back({skit_pkg::OP_INSERT, 16'hAAAA, 7'h55, 1'b0, none});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'h5555, 7'h00, 1'b0, none});
		directed_cmds.push_back({skit_pkg::OP_LOOKUP, 16'hAAAA, 7'h00, 1'b0, none});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_cmds[i]) begin
			c = directed_cmds[i];
			send_word(c.op, c.key, c.pos, c.typed, c.result);
		end

		// random traffic in idling phases; inserts dominate so the table fills
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
					holds_requested++;   // back the block up while words keep coming
				end
				1: begin
					src_idle_pct = 86;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 86;
				end
				default: begin
					src_idle_pct = 10;
					sink_stall_pct = 10;
				end
			endcase
			for (n = 0; n < RANDOM_WORDS; n++) begin
				op = ($urandom_range(99) < 65) ? skit_pkg::OP_INSERT : skit_pkg::OP_LOOKUP;
				pos = 7'($urandom_range(127));
				pick = $urandom_range(99);
				key = 16'($urandom_range(16'hFFFF));
				if (table_count > 0) begin
					if (op == skit_pkg::OP_INSERT) begin
						// fresh key, a stored key, or a neighbor of one
						if (pick >= 85)
							key = table_keys[$urandom_range(table_count - 1)] + 16'd1;
						else if (pick >= 65)
							key = table_keys[$urandom_range(table_count - 1)];
					end else if (pick < 60) begin
						key = table_keys[$urandom_range(table_count - 1)];
					end
				end
				send_word(op, key, pos, 1'b0, none);
			end
		end

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("sorted_key_index_table_tb OK");
		else
			$display("sorted_key_index_table_tb NOT OK");
		$finish;
	end

endmodule
